[src/gf2_13_ext_poly_multiplier_macros.svh]
// Assertion helpers for the extension field multiplier
`ifndef GF2_13_EXT_POLY_MULTIPLIER_MACROS_SVH
`define GF2_13_EXT_POLY_MULTIPLIER_MACROS_SVH

// Same-cycle implication, held off during reset
`define GFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define GFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gfm_pkg.sv]
package gfm_pkg;

    localparam int NUM_COEFFS = 128;
    localparam int FIELD_BITS = 13;
    localparam int OUT_GROUP  = 4;
    localparam int NUM_LANES  = 16;
    localparam int NUM_CHUNKS = NUM_COEFFS / NUM_LANES;
    localparam int CHUNK_W    = $clog2(NUM_CHUNKS);
    localparam int IDX_W      = $clog2(NUM_COEFFS);
    localparam int NUM_GROUPS = NUM_COEFFS / OUT_GROUP;
    localparam int GRP_W      = $clog2(NUM_GROUPS);
    localparam int RED_LEN    = FIELD_BITS - 1;

    typedef logic [FIELD_BITS-1:0] coeff_t;
    typedef coeff_t lane_vec_t [NUM_LANES];
    typedef coeff_t group_vec_t [OUT_GROUP];

    // x^(13+k) mod x^13+x^4+x^3+x+1
    localparam coeff_t RED_TBL [RED_LEN] = '{
        13'h001B, 13'h0036, 13'h006C, 13'h00D8, 13'h01B0, 13'h0360,
        13'h06C0, 13'h0D80, 13'h1B00, 13'h161B, 13'h0C2D, 13'h185A
    };

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               step;
        logic [CHUNK_W-1:0] chunk;
        logic               drain;
    } acc_ctrl_t;

endpackage

[src/gf2_13_ext_poly_multiplier.sv]
// Channel | Ports | tdata fields (low bit up)                     | tlast
// input   | s_*   | a_coeff[12:0], b_coeff[25:13], pad to 32       | -
// result  | m_*   | coeff_0..coeff_3 at 13 bits each, pad to 56    | last_group
//
// 128 words load, one per cycle while s_tvalid is high, into shift lines.
// Compute is a Horner pass over a_127..a_0: 16 multiplier lanes cover the
// 128 coefficients of b chunk by chunk in each step.
// Results then drain as 32 words, one per cycle while m_tready is high.
// aresetn (synchronous, active low) returns the block to loading, count zero.
// Input is not taken during compute or drain; a stalled result word holds.
module gf2_13_ext_poly_multiplier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // a_coeff[12:0], b_coeff[25:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // coeff_0, coeff_1, coeff_2, coeff_3 (13 bits each)
    output logic        m_tlast    // last_group
);
    import gfm_pkg::*;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   load_cnt_reg;
    logic [IDX_W-1:0]   step_cnt_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [GRP_W-1:0]   grp_cnt_reg;

    coeff_t     a_sr_reg [NUM_COEFFS];
    coeff_t     b_sr_reg [NUM_COEFFS];
    lane_vec_t  prod;
    group_vec_t grp;
    acc_ctrl_t  ctrl;

    logic in_acc, out_acc, load_done, calc_done;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign load_done = in_acc && (load_cnt_reg == IDX_W'(NUM_COEFFS - 1));
    assign calc_done = (state_reg == ST_CALC) && (step_cnt_reg == IDX_W'(NUM_COEFFS - 1))
                       && (chunk_reg == CHUNK_W'(NUM_CHUNKS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (load_done) state_next = ST_CALC;
            ST_CALC: if (calc_done) state_next = ST_SEND;
            ST_SEND: if (out_acc && m_tlast) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctrl       = '0;
        ctrl.chunk = chunk_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready   = 1'b1;
                ctrl.clear = load_done;
            end
            ST_CALC: ctrl.step = 1'b1;
            ST_SEND: begin
                m_tvalid   = 1'b1;
                ctrl.drain = m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            step_cnt_reg <= '0;
            chunk_reg    <= '0;
            grp_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (in_acc) load_cnt_reg <= load_cnt_reg + 1'b1;
            if (state_reg == ST_CALC) begin
                chunk_reg <= chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_W'(NUM_CHUNKS - 1)) begin
                    step_cnt_reg <= step_cnt_reg + 1'b1;
                end
            end
            if (out_acc) grp_cnt_reg <= grp_cnt_reg + 1'b1;
        end
    end

    // a: shift in at the bottom on load, advance toward the bottom per step
    // b: shift in at the top on load, rotate one chunk per compute cycle
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_sr_reg[0]            <= s_tdata[FIELD_BITS-1:0];
            b_sr_reg[NUM_COEFFS-1] <= s_tdata[2*FIELD_BITS-1:FIELD_BITS];
            for (int k = 1; k < NUM_COEFFS; k++) begin
                a_sr_reg[k]   <= a_sr_reg[k-1];
                b_sr_reg[k-1] <= b_sr_reg[k];
            end
        end else if (state_reg == ST_CALC) begin
            for (int k = 0; k < NUM_COEFFS; k++) begin
                b_sr_reg[k] <= b_sr_reg[(k + NUM_LANES) % NUM_COEFFS];
            end
            if (chunk_reg == CHUNK_W'(NUM_CHUNKS - 1)) begin
                for (int k = 0; k < NUM_COEFFS - 1; k++) begin
                    a_sr_reg[k] <= a_sr_reg[k+1];
                end
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        gfm_lane u_lane (
            .x(a_sr_reg[0]),
            .y(b_sr_reg[l]),
            .z(prod[l])
        );
    end

    gfm_accum u_accum (
        .aclk(aclk),
        .ctrl(ctrl),
        .prod(prod),
        .grp (grp)
    );

    assign m_tdata = {4'b0, grp[3], grp[2], grp[1], grp[0]};
    assign m_tlast = (state_reg == ST_SEND) && (grp_cnt_reg == GRP_W'(NUM_GROUPS - 1));

`include "gf2_13_ext_poly_multiplier_macros.svh"

    `GFM_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while results pending")
    `GFM_ASSERT_NOW(a_last_valid, m_tlast, m_tvalid, "last marked without valid word")
    `GFM_ASSERT_NEXT(a_reload, out_acc && m_tlast, s_tready, "not reloading after last word")
    `GFM_ASSERT_NEXT(a_start, load_done, !s_tready && !m_tvalid, "compute did not start")

endmodule

[src/gfm_lane.sv]
module gfm_lane (
    input  gfm_pkg::coeff_t x,
    input  gfm_pkg::coeff_t y,
    output gfm_pkg::coeff_t z
);
    import gfm_pkg::*;

    logic [2*FIELD_BITS-2:0] clmul;

    // carry-less multiply
    always_comb begin
        clmul = '0;
        for (int k = 0; k < FIELD_BITS; k++) begin
            if (y[k]) begin
                clmul = clmul ^ ({{(FIELD_BITS-1){1'b0}}, x} << k);
            end
        end
    end

    // reduce the high bits through the constant table
    always_comb begin
        z = clmul[FIELD_BITS-1:0];
        for (int k = 0; k < RED_LEN; k++) begin
            if (clmul[FIELD_BITS+k]) begin
                z = z ^ RED_TBL[k];
            end
        end
    end

endmodule

[src/gfm_accum.sv]
module gfm_accum (
    input  logic                aclk,
    input  gfm_pkg::acc_ctrl_t  ctrl,
    input  gfm_pkg::lane_vec_t  prod,
    output gfm_pkg::group_vec_t grp
);
    import gfm_pkg::*;

    coeff_t acc_reg  [NUM_COEFFS];
    coeff_t acc_next [NUM_COEFFS];
    coeff_t acc_shft [NUM_COEFFS];

    // multiply the accumulator by y modulo y^128+y^7+y^2+y+1
    always_comb begin
        for (int j = 0; j < NUM_COEFFS; j++) begin
            if (j == 0) begin
                acc_shft[j] = acc_reg[NUM_COEFFS-1];
            end else if (j == 1 || j == 2 || j == 7) begin
                acc_shft[j] = acc_reg[j-1] ^ acc_reg[NUM_COEFFS-1];
            end else begin
                acc_shft[j] = acc_reg[j-1];
            end
        end
    end

    // clear; times y, merge lane products into chunk; drain a group
    always_comb begin
        for (int j = 0; j < NUM_COEFFS; j++) begin
            acc_next[j] = acc_reg[j];
            if (ctrl.clear) begin
                acc_next[j] = '0;
            end else if (ctrl.step) begin
                if (ctrl.chunk == '0) begin
                    acc_next[j] = acc_shft[j];
                end
                if (ctrl.chunk == CHUNK_W'(j / NUM_LANES)) begin
                    acc_next[j] = acc_next[j] ^ prod[j % NUM_LANES];
                end
            end else if (ctrl.drain) begin
                if (j + OUT_GROUP < NUM_COEFFS) begin
                    acc_next[j] = acc_reg[j+OUT_GROUP];
                end else begin
                    acc_next[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NUM_COEFFS; j++) begin
            acc_reg[j] <= acc_next[j];
        end
    end

    always_comb begin
        for (int c = 0; c < OUT_GROUP; c++) begin
            grp[c] = acc_reg[c];
        end
    end

endmodule
